// File: hdl/bres_pkg.sv
// Shared constants and types for the Bresenham line pixel generator.
package bres_pkg;

   localparam int CFG_WIDTH      = 13;
   localparam int IDX_BITS       = 24;
   localparam int COLOR_BITS     = 32;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int DEF_MAX_DIM    = 4096;
   localparam int DEF_COORD_BITS = 16;

   localparam logic [CFG_WIDTH-1:0] FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [CFG_WIDTH-1:0] FRAME_HEIGHT_RESET = 13'd480;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_STEP = 1'b1;

   // register select, taken from paddr bit 2
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic load;
      logic step;
   } step_cmd_type;

   typedef struct packed {
      logic busy;
      logic fin;
   } step_stat_type;

endpackage

// File: hdl/bres_step.sv
// Line state and Bresenham error update for one pixel per step transfer.
module bres_step import bres_pkg::*; #(
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  step_cmd_type                 cmd,
   input  logic signed [COORD_BITS-1:0] start_x,
   input  logic signed [COORD_BITS-1:0] start_y,
   input  logic signed [COORD_BITS-1:0] end_x,
   input  logic signed [COORD_BITS-1:0] end_y,
   input  logic [COLOR_BITS-1:0]        line_color,
   output logic [COORD_BITS-1:0]        cur_x,
   output logic [COORD_BITS-1:0]        cur_y,
   output logic [COLOR_BITS-1:0]        held_color,
   output step_stat_type                stat
);

   localparam int CB = COORD_BITS;

   logic [CB-1:0]        cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [CB-1:0]        target_x_ff, target_x_in, target_y_ff, target_y_in;
   logic [CB-1:0]        delta_x_ff, delta_x_in, delta_y_ff, delta_y_in;
   logic                 x_neg_ff, x_neg_in, y_neg_ff, y_neg_in;
   logic signed [CB+1:0] err_ff, err_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;
   logic                 busy_ff, busy_in;

   logic signed [CB:0]   diff_x, diff_y;
   logic [CB-1:0]        load_dx, load_dy;
   logic signed [CB+2:0] e2;
   logic                 step_x, step_y, fin;

   assign fin = (cur_x_ff == target_x_ff) && (cur_y_ff == target_y_ff);

   always_comb begin
      diff_x  = {end_x[CB-1], end_x} - {start_x[CB-1], start_x};
      diff_y  = {end_y[CB-1], end_y} - {start_y[CB-1], start_y};
      load_dx = diff_x[CB] ? CB'(-diff_x) : CB'(diff_x);
      load_dy = diff_y[CB] ? CB'(-diff_y) : CB'(diff_y);

      e2     = $signed({err_ff, 1'b0});
      step_x = e2 > -$signed({3'b000, delta_y_ff});
      step_y = e2 < $signed({3'b000, delta_x_ff});

      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      target_x_in = target_x_ff;
      target_y_in = target_y_ff;
      delta_x_in  = delta_x_ff;
      delta_y_in  = delta_y_ff;
      x_neg_in    = x_neg_ff;
      y_neg_in    = y_neg_ff;
      err_in      = err_ff;
      color_in    = color_ff;
      busy_in     = busy_ff;

      if (cmd.load) begin
         cur_x_in    = start_x;
         cur_y_in    = start_y;
         target_x_in = end_x;
         target_y_in = end_y;
         delta_x_in  = load_dx;
         delta_y_in  = load_dy;
         x_neg_in    = !(start_x < end_x);
         y_neg_in    = !(start_y < end_y);
         err_in      = $signed({2'b00, load_dx}) - $signed({2'b00, load_dy});
         color_in    = line_color;
         busy_in     = 1'b1;
      end else if (cmd.step && busy_ff) begin
         if (fin) begin
            busy_in = 1'b0;
         end else begin
            err_in = err_ff
                     - (step_x ? $signed({2'b00, delta_y_ff}) : '0)
                     + (step_y ? $signed({2'b00, delta_x_ff}) : '0);
            if (step_x) begin
               cur_x_in = x_neg_ff ? cur_x_ff - CB'(1) : cur_x_ff + CB'(1);
            end
            if (step_y) begin
               cur_y_in = y_neg_ff ? cur_y_ff - CB'(1) : cur_y_ff + CB'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      target_x_ff <= target_x_in;
      target_y_ff <= target_y_in;
      delta_x_ff  <= delta_x_in;
      delta_y_ff  <= delta_y_in;
      x_neg_ff    <= x_neg_in;
      y_neg_ff    <= y_neg_in;
      err_ff      <= err_in;
      color_ff    <= color_in;
   end

   assign cur_x      = cur_x_ff;
   assign cur_y      = cur_y_ff;
   assign held_color = color_ff;
   assign stat.busy  = busy_ff;
   assign stat.fin   = fin;

endmodule

// File: hdl/bres_pix.sv
// Frame clipping and linear index of the current pixel.
module bres_pix import bres_pkg::*; #(
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int MAX_DIM    = DEF_MAX_DIM
) (
   input  logic [COORD_BITS-1:0] cur_x,
   input  logic [COORD_BITS-1:0] cur_y,
   input  logic [CFG_WIDTH-1:0]  frame_width,
   input  logic [CFG_WIDTH-1:0]  frame_height,
   output logic                  visible,
   output logic [IDX_BITS-1:0]   pixel_index
);

   localparam int CB       = COORD_BITS;
   localparam int DIM_BITS = $clog2(MAX_DIM + 1);
   localparam int CMP_W    = (CFG_WIDTH > DIM_BITS) ? CFG_WIDTH : DIM_BITS;
   localparam int VIS_W    = (CB > DIM_BITS) ? CB : DIM_BITS;
   localparam int PROD_W   = CB + DIM_BITS + 1;

   logic [DIM_BITS-1:0] clip_w, clip_h;
   logic [PROD_W-1:0]   lin;

   // Clamp frame registers to the largest supported frame
   assign clip_w = (CMP_W'(frame_width) > CMP_W'(MAX_DIM)) ? DIM_BITS'(MAX_DIM)
                                                           : DIM_BITS'(frame_width);
   assign clip_h = (CMP_W'(frame_height) > CMP_W'(MAX_DIM)) ? DIM_BITS'(MAX_DIM)
                                                            : DIM_BITS'(frame_height);

   assign visible = !cur_x[CB-1] && !cur_y[CB-1]
                    && (VIS_W'(cur_x) < VIS_W'(clip_w))
                    && (VIS_W'(cur_y) < VIS_W'(clip_h));

   assign lin = PROD_W'(cur_y) * PROD_W'(clip_w) + PROD_W'(cur_x);

   assign pixel_index = visible ? IDX_BITS'(lin) : '0;

endmodule

// File: hdl/bresenham_line_pixel_generator.sv
// Top level of the Bresenham line pixel generator: config registers and result register.
//
//   port group   dir   carries
//   req_*        in    load (line end points, colour) or step request
//   rsp_*        out   one pixel: coordinates, index, colour, visible, last
//   csr_*        in    frame_width at 0x0, frame_height at 0x4
//
// One transfer per cycle on req when req_tready is high; a step's pixel is in the
// result register the next cycle; the y*width multiply ahead of it is combinational.
// req_tready is low only while a held pixel waits on rsp_tready.
// Reset clears the busy flag, the result valid and restores 640 x 480.
module bresenham_line_pixel_generator import bres_pkg::*; #(
   parameter int MAX_DIM    = DEF_MAX_DIM,
   parameter int COORD_BITS = DEF_COORD_BITS,
   localparam int REQ_TDATA_W = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8,
   localparam int RSP_TDATA_W = ((2 * COORD_BITS + IDX_BITS + COLOR_BITS + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   // start_x, start_y, end_x, end_y, line_color (low to high)
   input  logic [REQ_TDATA_W-1:0]   req_tdata,
   // func
   input  logic                     req_tuser,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // pixel_x, pixel_y, pixel_index, pixel_color (low to high)
   output logic [RSP_TDATA_W-1:0]   rsp_tdata,
   // visible
   output logic                     rsp_tuser,
   output logic                     rsp_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int CB = COORD_BITS;

   logic [CFG_WIDTH-1:0]  width_ff, width_in, height_ff, height_in;
   logic                  csr_wr;

   logic                  req_fire;
   step_cmd_type          cmd;
   step_stat_type         stat;
   logic [CB-1:0]         cur_x, cur_y;
   logic [COLOR_BITS-1:0] held_color;
   logic                  vis;
   logic [IDX_BITS-1:0]   idx;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CB-1:0]         px_ff, py_ff;
   logic [IDX_BITS-1:0]   idx_ff;
   logic [COLOR_BITS-1:0] color_ff;
   logic                  vis_ff, last_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_FRAME_WIDTH:  width_in  = csr_pwdata[CFG_WIDTH-1:0];
            REG_FRAME_HEIGHT: height_in = csr_pwdata[CFG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_FRAME_WIDTH:  csr_prdata = CSR_DATA_BITS'(width_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DATA_BITS'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_WIDTH_RESET;
         height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // input handshake
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign cmd.load   = req_fire && (req_tuser == FUNC_LOAD);
   assign cmd.step   = req_fire && (req_tuser == FUNC_STEP);

   bres_step #(
      .COORD_BITS (COORD_BITS)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .start_x    (req_tdata[CB-1:0]),
      .start_y    (req_tdata[2*CB-1:CB]),
      .end_x      (req_tdata[3*CB-1:2*CB]),
      .end_y      (req_tdata[4*CB-1:3*CB]),
      .line_color (req_tdata[4*CB+COLOR_BITS-1:4*CB]),
      .cur_x      (cur_x),
      .cur_y      (cur_y),
      .held_color (held_color),
      .stat       (stat)
   );

   bres_pix #(
      .COORD_BITS (COORD_BITS),
      .MAX_DIM    (MAX_DIM)
   ) u_pix (
      .cur_x        (cur_x),
      .cur_y        (cur_y),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .visible      (vis),
      .pixel_index  (idx)
   );

   // result register: load on every free slot, hold while stalled
   assign rsp_valid_in = req_tready ? (cmd.step && stat.busy) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         px_ff    <= cur_x;
         py_ff    <= cur_y;
         idx_ff   <= idx;
         color_ff <= held_color;
         vis_ff   <= vis;
         last_ff  <= stat.fin;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({color_ff, idx_ff, py_ff, px_ff});
   assign rsp_tuser  = vis_ff;
   assign rsp_tlast  = last_ff;

   // a step on an active line always yields a pixel next cycle
   a_step_gives_pixel: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && stat.busy) |=> rsp_tvalid)
      else $error("step on active line produced no pixel");

   // the end-point pixel returns the rasterizer to idle
   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && stat.busy && stat.fin) |=> !stat.busy)
      else $error("line still busy after end-point pixel");

   // a load starts a line and never emits a pixel by itself
   a_load_no_pixel: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (stat.busy && !$rose(rsp_tvalid)))
      else $error("load misbehaved");

   // clipped pixels carry a zero index
   a_clip_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (idx_ff == '0))
      else $error("invisible pixel with nonzero index");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the Bresenham line pixel generator: directed lines, then random ones.
module tb_top;
   import bres_pkg::*;

   localparam logic [CSR_ADDR_BITS-1:0] ADDR_FRAME_WIDTH  = {REG_FRAME_WIDTH, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_FRAME_HEIGHT = {REG_FRAME_HEIGHT, 2'b00};
   localparam int RANDOM_ITEMS = 700;
   localparam int RANDOM_PHASES = 7;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [23:0]        index;
      logic [31:0]        color;
      logic               visible;
      logic               is_last;
   } pixel_type;

   logic                     clock = 1'b0;
   logic                     reset;
   // start_x, start_y, end_x, end_y, line_color (low to high)
   logic [95:0]              req_tdata;
   // func
   logic                     req_tuser;
   logic                     req_tvalid;
   logic                     req_tready;
   // pixel_x, pixel_y, pixel_index, pixel_color (low to high)
   logic [87:0]              rsp_tdata;
   // visible
   logic                     rsp_tuser;
   logic                     rsp_tlast;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   bresenham_line_pixel_generator uut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // rasterizer state as the testbench tracks it
   logic [CFG_WIDTH-1:0] frame_w_q = FRAME_WIDTH_RESET;
   logic [CFG_WIDTH-1:0] frame_h_q = FRAME_HEIGHT_RESET;
   logic signed [15:0]   pos_x = '0, pos_y = '0, goal_x = '0, goal_y = '0;
   logic [15:0]          span_x = '0, span_y = '0;
   logic                 x_back = 1'b0, y_back = 1'b0;
   logic signed [17:0]   err_acc = '0;
   logic [31:0]          color_q = '0;
   bit                   line_busy = 1'b0;

   pixel_type pending_pixels[$];
   int     mismatches = 0;
   int     items_sent = 0;
   bit     quiet = 1'b0;
   int     hold_cycles = 0;

   function automatic int clip_dim(logic [CFG_WIDTH-1:0] v);
      return (int'(v) > DEF_MAX_DIM) ? DEF_MAX_DIM : int'(v);
   endfunction

   // Work out the pixel, if any, that one accepted item produces.
   task automatic rasterize(input logic func, input logic signed [15:0] sx, sy, ex, ey,
                            input logic [31:0] color);
      int     w, h, e2;
      pixel_type px;
      if (func == FUNC_LOAD) begin
         pos_x   = sx;
         pos_y   = sy;
         goal_x  = ex;
         goal_y  = ey;
         span_x  = (ex > sx) ? 16'(int'(ex) - int'(sx)) : 16'(int'(sx) - int'(ex));
         span_y  = (ey > sy) ? 16'(int'(ey) - int'(sy)) : 16'(int'(sy) - int'(ey));
         x_back  = !(sx < ex);
         y_back  = !(sy < ey);
         err_acc = 18'(int'(span_x) - int'(span_y));
         color_q = color;
         line_busy = 1'b1;
      end else if (line_busy) begin
         w = clip_dim(frame_w_q);
         h = clip_dim(frame_h_q);
         px.x = pos_x;
         px.y = pos_y;
         px.color = color_q;
         px.visible = int'(pos_x) >= 0 && int'(pos_x) < w && int'(pos_y) >= 0 && int'(pos_y) < h;
         px.index = px.visible ? 24'(int'(pos_y) * w + int'(pos_x)) : '0;
         px.is_last = (pos_x == goal_x) && (pos_y == goal_y);
         pending_pixels.push_back(px);
         if (px.is_last) begin
            line_busy = 1'b0;
         end else begin
            e2 = 2 * int'(err_acc);
            if (e2 > -int'(span_y)) begin
               err_acc = 18'(int'(err_acc) - int'(span_y));
               pos_x = x_back ? pos_x - 16'sd1 : pos_x + 16'sd1;
            end
            if (e2 < int'(span_x)) begin
               err_acc = 18'(int'(err_acc) + int'(span_x));
               pos_y = y_back ? pos_y - 16'sd1 : pos_y + 16'sd1;
            end
         end
      end
   endtask

   task automatic send_item(input logic func, input logic signed [15:0] sx, sy, ex, ey,
                            input logic [31:0] color);
      if (!quiet) begin
         while ($urandom_range(99) < 9) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {color, ey, ex, sy, sx};
      do @(posedge clock); while (!req_tready);
      rasterize(func, sx, sy, ex, ey, color);
      items_sent++;
   endtask

   // step with junk in the data fields, which a step must ignore
   task automatic step_pixel();
      send_item(FUNC_STEP, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                $urandom);
   endtask

   task automatic finish_line();
      while (line_busy) step_pixel();
   endtask

   task automatic draw_line(input logic signed [15:0] sx, sy, ex, ey, input logic [31:0] color);
      send_item(FUNC_LOAD, sx, sy, ex, ey, color);
      finish_line();
   endtask

   // Stop sending and let every expected pixel arrive before going on.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CFG_WIDTH-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      // upper bits are junk; only the low CFG_WIDTH bits are kept
      csr_pwdata  <= {(CSR_DATA_BITS - CFG_WIDTH)'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (addr == ADDR_FRAME_WIDTH) frame_w_q = value;
      else frame_h_q = value;
      @(posedge clock);
   endtask

   task automatic set_frame(input logic [CFG_WIDTH-1:0] w, h);
      drain();
      csr_write(ADDR_FRAME_WIDTH, w);
      csr_write(ADDR_FRAME_HEIGHT, h);
   endtask

   function automatic logic [CFG_WIDTH-1:0] pick_dim();
      case ($urandom_range(7))
         0: return 13'd0;
         1: return 13'd1;
         2: return 13'd4096;
         3: return 13'd8191;
         4: return 13'd4097;
         5: return 13'($urandom_range(16, 64));
         default: return 13'($urandom);
      endcase
   endfunction

   task automatic test_idle_step();
      step_pixel();
      step_pixel();
   endtask

   task automatic test_single_point();
      send_item(FUNC_LOAD, 16'sd5, 16'sd7, 16'sd5, 16'sd7, 32'h0000_0001);
      step_pixel();
      step_pixel();
   endtask

   task automatic test_extremes();
      send_item(FUNC_LOAD, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 32'hFFFF_FFFF);
      repeat (3) step_pixel();
      // reload in mid-line: the old line is dropped
      send_item(FUNC_LOAD, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 32'h5A5A_A5A5);
      repeat (2) step_pixel();
      draw_line(16'sd0, 16'sd0, 16'sd3, 16'sd1, 32'h0000_0000);
      // crosses the right and bottom edges of the reset frame
      draw_line(16'sd638, 16'sd478, 16'sd641, 16'sd481, 32'hAAAA_5555);
   endtask

   task automatic test_frame_limits();
      set_frame(13'd0, 13'd0);
      draw_line(16'sd0, 16'sd0, 16'sd2, 16'sd2, 32'h1234_5678);
      set_frame(13'd4096, 13'd4096);
      draw_line(16'sd4094, 16'sd4095, 16'sd4097, 16'sd4095, 32'h8765_4321);
      draw_line(16'sd4095, 16'sd4093, 16'sd4095, 16'sd4097, 32'h0F0F_F0F0);
      set_frame(13'd8191, 13'd8191);
      draw_line(16'sd4094, 16'sd0, 16'sd4097, 16'sd1, 32'hDEAD_0001);
      set_frame(13'd1, 13'd1);
      draw_line(-16'sd1, -16'sd1, 16'sd1, 16'sd1, 32'h0000_FFFF);
      set_frame(13'd4097, 13'd16);
      draw_line(16'sd4095, 16'sd14, 16'sd4097, 16'sd17, 32'hFFFF_0000);
      set_frame(FRAME_WIDTH_RESET, FRAME_HEIGHT_RESET);
   endtask

   task automatic test_backpressure();
      // the receiver holds off while a long line keeps the sender busy
      hold_cycles = 200;
      draw_line(16'sd0, 16'sd0, 16'sd300, 16'sd40, 32'hC0DE_C0DE);
   endtask

   task automatic random_line();
      int kind, cut, ww, wh;
      logic signed [15:0] sx, sy, ex, ey;
      kind = $urandom_range(99);
      if (kind < 5 && !line_busy) step_pixel();
      ww = clip_dim(frame_w_q);
      wh = clip_dim(frame_h_q);
      if (ww < 16) ww = 64;
      if (wh < 16) wh = 64;
      if (kind < 12) begin
         sx = 16'($urandom);
         sy = 16'($urandom);
         ex = 16'($urandom);
         ey = 16'($urandom);
         cut = $urandom_range(1, 6);
      end else begin
         sx = 16'($urandom_range(ww + 16) - 8);
         sy = 16'($urandom_range(wh + 16) - 8);
         ex = 16'(int'(sx) + int'($urandom_range(48)) - 24);
         ey = 16'(int'(sy) + int'($urandom_range(48)) - 24);
         cut = (kind < 22) ? int'($urandom_range(8)) : -1;
      end
      send_item(FUNC_LOAD, sx, sy, ex, ey, $urandom);
      if (cut >= 0) begin
         repeat (cut) if (line_busy) step_pixel();
      end else begin
         finish_line();
         if (kind >= 95) step_pixel();
      end
   endtask

   task automatic test_random_lines();
      int phase_end;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_frame(pick_dim(), pick_dim());
         quiet = (phase == 2);
         phase_end = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
         while (items_sent < phase_end) random_line();
      end
      quiet = 1'b0;
   endtask

   initial begin : rsp_side
      int n;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            n = hold_cycles;
            hold_cycles = 0;
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= quiet || ($urandom_range(99) >= 9);
         end
      end
   end

   always @(posedge clock) begin : pixel_check
      pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected pixel transfer: x %0d y %0d", $signed(rsp_tdata[15:0]),
                   $signed(rsp_tdata[31:16]));
            mismatches++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_tdata[15:0] !== want.x) begin
               $error("pixel_x: expected %0d, got %0d", want.x, $signed(rsp_tdata[15:0]));
               mismatches++;
            end
            if (rsp_tdata[31:16] !== want.y) begin
               $error("pixel_y: expected %0d, got %0d", want.y, $signed(rsp_tdata[31:16]));
               mismatches++;
            end
            if (rsp_tdata[55:32] !== want.index) begin
               $error("pixel_index: expected %0d, got %0d", want.index, rsp_tdata[55:32]);
               mismatches++;
            end
            if (rsp_tdata[87:56] !== want.color) begin
               $error("pixel_color: expected %h, got %h", want.color, rsp_tdata[87:56]);
               mismatches++;
            end
            if (rsp_tuser !== want.visible) begin
               $error("visible: expected %0b, got %0b", want.visible, rsp_tuser);
               mismatches++;
            end
            if (rsp_tlast !== want.is_last) begin
               $error("last: expected %0b, got %0b", want.is_last, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   initial begin
      reset       = 1'b1;
      req_tdata   = '0;
      req_tuser   = FUNC_LOAD;
      req_tvalid  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_step();
      test_single_point();
      test_extremes();
      test_frame_limits();
      test_backpressure();
      test_random_lines();
      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("simulation failed");
      $finish;
   end

endmodule

// File: files.f
hdl/bres_pkg.sv
hdl/bres_step.sv
hdl/bres_pix.sv
hdl/bresenham_line_pixel_generator.sv
tb/tb_top.sv
